// ===== rtl/iokvt_pkg.sv =====
// shared types and codes for the insertion-ordered key-value table
package iokvt_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int PORT_W   = 32;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EXISTS    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_AT_END    = 3'd4;

  // search token passed from cell to cell
  typedef struct packed {
    logic active;    // a search is at this cell
    logic by_index;  // match on cell index (cursor read) instead of key
    logic hit;       // an earlier cell already matched
  } tok_t;

endpackage

// ===== rtl/insertion_ordered_key_value_table_core.sv =====
// top level of the insertion-ordered key-value table with a read cursor
//
// usage
//   in_*  : one request beat per item (kind, lookup_key, entry_value)
//   out_* : one result beat per request (found_value, status, entry_count,
//           cursor_at_end), in request order
// the pairs live in a row of ENTRIES cells; a lookup or a cursor read sends
// a search token down the row, one cell per cycle, and the first live cell
// that matches drops its value into the token
// steps: insert, lookup and read pass the launch register, the ENTRIES cell
// stages, tail capture and finish before out_valid; cursor to start,
// advance and unused kinds go straight to finish
// one request in flight at a time, so a new request is accepted only after
// the previous one has left the finish step
// in_ready is high whenever no request is in flight, even while a result
// waits in the output register; a stalled receiver holds the finish step
// and with it the next accept
// reset: entry count and cursor go to zero, nothing in flight, no result
// pending; stored pairs are not cleared and are only read below the count
module insertion_ordered_key_value_table_core import iokvt_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [PORT_W-1:0]   in_lookup_key,
  input  logic [PORT_W-1:0]   in_entry_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PORT_W-1:0]   out_found_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic                out_cursor_at_end
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cursor_r, cursor_nxt;

  // request held while in flight
  logic [KIND_W-1:0]     kind_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // search result captured at the tail of the chain
  logic                  hit_r, hit_nxt;
  logic [VALUE_BITS-1:0] hit_val_r;

  // token launch register feeding cell 0
  tok_t                  tok0_r, tok0_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]     out_val_r;
  logic [STATUS_W-1:0]   out_stat_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  out_end_r;

  logic [63:0]           key_ext, val_ext, res_ext;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;
  logic                  accept, finish, search_kind;
  logic                  wr_en;
  logic [STATUS_W-1:0]   stat_c;
  logic [VALUE_BITS-1:0] res_c;
  logic [31:0]           cnt_ext;

  tok_t                  chain_tok [ENTRIES+1];
  logic [KEY_BITS-1:0]   chain_key [ENTRIES+1];
  logic [VALUE_BITS-1:0] chain_val [ENTRIES+1];

  // only the low KEY_BITS / VALUE_BITS of the port fields take part
  assign key_ext = {32'b0, in_lookup_key};
  assign val_ext = {32'b0, in_entry_value};
  assign in_key  = key_ext[KEY_BITS-1:0];
  assign in_val  = val_ext[VALUE_BITS-1:0];

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign search_kind = (in_kind inside {KIND_INSERT, KIND_LOOKUP, KIND_READ});
  assign finish      = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // row of cells
  assign chain_tok[0] = tok0_r;
  assign chain_key[0] = key_r;
  assign chain_val[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    iokvt_cell #(
      .INDEX      (g),
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (chain_tok[g]),
      .key_i    (chain_key[g]),
      .val_i    (chain_val[g]),
      .tok_o    (chain_tok[g+1]),
      .key_o    (chain_key[g+1]),
      .val_o    (chain_val[g+1]),
      .count_i  (count_r),
      .cursor_i (cursor_r),
      .wr_en_i  (wr_en),
      .wr_idx_i (count_r[IDX_W-1:0]),
      .wr_key_i (key_r),
      .wr_val_i (val_r)
    );
  end

  // finish step: decide status, update count and cursor
  always_comb begin
    stat_c     = STAT_OK;
    res_c      = '0;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    wr_en      = 1'b0;
    case (kind_r)
      KIND_INSERT: begin
        // duplicate check comes before the full check
        if (hit_r) begin
          stat_c = STAT_EXISTS;
        end else if (count_r >= FULL_CNT) begin
          stat_c = STAT_FULL;
        end else begin
          wr_en      = finish;
          count_nxt  = count_r + 1'b1;
          cursor_nxt = '0;
        end
      end
      KIND_LOOKUP: begin
        if (hit_r) begin
          res_c = hit_val_r;
        end else begin
          stat_c = STAT_NOT_FOUND;
        end
      end
      KIND_START: begin
        cursor_nxt = '0;
      end
      KIND_READ: begin
        // only the cell at the cursor can hit, and only when below the count
        if (hit_r) begin
          res_c = hit_val_r;
        end else begin
          stat_c = STAT_AT_END;
        end
      end
      KIND_ADVANCE: begin
        if (cursor_r < count_r) begin
          cursor_nxt = cursor_r + 1'b1;
        end else begin
          stat_c = STAT_AT_END;
        end
      end
      default: begin
        // unused kinds change nothing
      end
    endcase
  end

  assign res_ext = 64'(res_c);
  assign cnt_ext = 32'(count_nxt);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    tok0_nxt        = '0;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt = 1'b0;
          if (search_kind) begin
            tok0_nxt.active   = 1'b1;
            tok0_nxt.by_index = (in_kind == KIND_READ);
            state_nxt         = ST_SEARCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        if (chain_tok[ENTRIES].active) begin
          hit_nxt   = chain_tok[ENTRIES].hit;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      tok0_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok0_r      <= tok0_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      val_r  <= in_val;
    end
    if ((state_r == ST_SEARCH) && chain_tok[ENTRIES].active) begin
      hit_val_r <= chain_val[ENTRIES];
    end
    if (finish) begin
      out_val_r  <= res_ext[PORT_W-1:0];
      out_stat_r <= stat_c;
      out_cnt_r  <= cnt_ext[COUNT_W-1:0];
      out_end_r  <= (cursor_nxt >= count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found_value   = out_val_r;
  assign out_status        = out_stat_r;
  assign out_entry_count   = out_cnt_r;
  assign out_cursor_at_end = out_end_r;

endmodule

// ===== rtl/iokvt_cell.sv =====
// one table entry: stored pair plus one stage of the search chain
module iokvt_cell import iokvt_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tok_t                                  tok_i,
  input  logic [KEY_BITS-1:0]                   key_i,
  input  logic [VALUE_BITS-1:0]                 val_i,
  output tok_t                                  tok_o,
  output logic [KEY_BITS-1:0]                   key_o,
  output logic [VALUE_BITS-1:0]                 val_o,
  input  logic [$clog2(ENTRIES+1)-1:0]          count_i,
  input  logic [$clog2(ENTRIES+1)-1:0]          cursor_i,
  input  logic                                  wr_en_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_idx_i,
  input  logic [KEY_BITS-1:0]                   wr_key_i,
  input  logic [VALUE_BITS-1:0]                 wr_val_i
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [KEY_BITS-1:0]   ent_key_r;
  logic [VALUE_BITS-1:0] ent_val_r;
  tok_t                  tok_r, tok_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  live, match, take;

  always_comb begin
    live  = (MY_CNT < count_i);
    match = tok_i.by_index ? (MY_CNT == cursor_i) : (ent_key_r == key_i);
    take  = tok_i.active && !tok_i.hit && live && match;
    tok_nxt          = tok_i;
    tok_nxt.hit      = tok_i.hit || take;
    val_nxt          = take ? ent_val_r : val_i;
  end

  // entry storage, written only by an insert
  always_ff @(posedge clk) begin
    if (wr_en_i && (wr_idx_i == MY_IDX)) begin
      ent_key_r <= wr_key_i;
      ent_val_r <= wr_val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_i;
    val_r <= val_nxt;
  end

  assign tok_o = tok_r;
  assign key_o = key_r;
  assign val_o = val_r;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the insertion-ordered key-value table core
`timescale 1ns / 1ps

import iokvt_pkg::*;

localparam int TABLE_DEPTH = 16;

typedef struct {
  logic [PORT_W-1:0]   found_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic                cursor_at_end;
} kv_result_t;

class kv_table_scoreboard;
  logic [PORT_W-1:0] key_mem [TABLE_DEPTH];
  logic [PORT_W-1:0] val_mem [TABLE_DEPTH];
  int unsigned       pair_count = 0;
  int unsigned       cursor = 0;
  kv_result_t        pending_results [$];
  int unsigned       mismatches = 0;
  int unsigned       results_checked = 0;
  int unsigned       status_seen [5] = '{default: 0};

  // table behavior, applied to every accepted request beat
  function void note_request(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] key,
                             logic [PORT_W-1:0] value);
    kv_result_t exp;
    bit         hit;
    int unsigned slot;
    exp.found_value = '0;
    exp.status      = STAT_OK;
    hit  = 1'b0;
    slot = 0;
    for (int unsigned i = 0; i < pair_count; i++) begin
      if (!hit && key_mem[i] == key) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    case (kind)
      KIND_INSERT: begin
        if (hit) begin
          exp.status = STAT_EXISTS;
        end else if (pair_count >= TABLE_DEPTH) begin
          exp.status = STAT_FULL;
        end else begin
          key_mem[pair_count] = key;
          val_mem[pair_count] = value;
          pair_count++;
          cursor = 0;
        end
      end
      KIND_LOOKUP: begin
        if (hit) exp.found_value = val_mem[slot];
        else exp.status = STAT_NOT_FOUND;
      end
      KIND_START: cursor = 0;
      KIND_READ: begin
        if (cursor < pair_count) exp.found_value = val_mem[cursor];
        else exp.status = STAT_AT_END;
      end
      KIND_ADVANCE: begin
        if (cursor < pair_count) cursor++;
        else exp.status = STAT_AT_END;
      end
      default: ;
    endcase
    exp.entry_count   = COUNT_W'(pair_count);
    exp.cursor_at_end = (cursor >= pair_count);
    pending_results.push_back(exp);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task check_result(logic [PORT_W-1:0] found, logic [STATUS_W-1:0] status,
                    logic [COUNT_W-1:0] count, logic at_end);
    kv_result_t exp;
    if (pending_results.size() == 0) begin
      report("result beat with nothing expected");
      return;
    end
    exp = pending_results.pop_front();
    results_checked++;
    if (exp.status < 5) status_seen[exp.status]++;
    if (found !== exp.found_value)
      report($sformatf("found_value %h, want %h", found, exp.found_value));
    if (status !== exp.status)
      report($sformatf("status %0d, want %0d", status, exp.status));
    if (count !== exp.entry_count)
      report($sformatf("entry_count %0d, want %0d", count, exp.entry_count));
    if (at_end !== exp.cursor_at_end)
      report($sformatf("cursor_at_end %b, want %b", at_end, exp.cursor_at_end));
  endtask
endclass

module testbench;

  // kinds that the table ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1430;
  localparam int unsigned MAX_IDLE     = 17;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [PORT_W-1:0]   in_lookup_key;
  logic [PORT_W-1:0]   in_entry_value;
  logic                out_valid;
  logic                out_ready;
  logic [PORT_W-1:0]   out_found_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_cursor_at_end;

  // calm phases: the side runs without idle cycles for a while
  bit in_calm;
  bit out_calm;
  int unsigned requests_sent;

  kv_table_scoreboard sb;

  insertion_ordered_key_value_table_core #(
    .ENTRIES    (TABLE_DEPTH),
    .KEY_BITS   (32),
    .VALUE_BITS (32)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_lookup_key     (in_lookup_key),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found_value   (out_found_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_cursor_at_end (out_cursor_at_end)
  );

  always #10 clk = ~clk;

  // mostly random words, with the all-zero and all-one patterns now and then
  function automatic logic [PORT_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // one of the keys already in the table, or a fresh word on an empty table
  function automatic logic [PORT_W-1:0] stored_key();
    if (sb.pair_count == 0) return pick_word();
    return sb.key_mem[$urandom_range(0, sb.pair_count - 1)];
  endfunction

  // one of the kinds the table ignores
  function automatic logic [KIND_W-1:0] KIND_LOGIC_SPARE();
    return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
  endfunction

  // one request beat; called at a falling edge, returns at a falling edge
  // with valid still high so a back-to-back beat needs no extra edge
  task automatic send_request(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] key,
                              logic [PORT_W-1:0] value);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_lookup_key  <= key;
    in_entry_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, key, value);
    requests_sent++;
    @(negedge clk);
  endtask

  // result side: idle a drawn number of cycles, then take one beat
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 80 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_found_value, out_status, out_entry_count, out_cursor_at_end);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned issued;
    int unsigned mood_mark;
    int unsigned pick;
    int unsigned walk_len;
    logic [PORT_W-1:0] key;

    sb             = new;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_START;
    in_lookup_key  = '0;
    in_entry_value = '0;
    out_ready      = 1'b0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    requests_sent  = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: read and advance at end, lookup miss, ignored kinds, a start
    send_request(KIND_READ, '0, '1);
    send_request(KIND_ADVANCE, '1, '0);
    send_request(KIND_LOOKUP, '0, '0);
    send_request(KIND_SPARE_FIRST, '1, '1);
    send_request(KIND_SPARE_LAST, '1, '1);
    send_request(KIND_START, '0, '0);
    // extreme keys and values, then a duplicate insert and lookups that hit and miss
    send_request(KIND_INSERT, '0, '1);
    send_request(KIND_INSERT, '1, '0);
    send_request(KIND_INSERT, '0, 32'h0000_1234);
    send_request(KIND_LOOKUP, '0, '0);
    send_request(KIND_LOOKUP, '1, '0);
    send_request(KIND_LOOKUP, 32'h7fff_ffff, '0);
    // cursor walk to past the end and beyond
    send_request(KIND_READ, '0, '0);
    send_request(KIND_ADVANCE, '0, '0);
    send_request(KIND_READ, '0, '0);
    send_request(KIND_ADVANCE, '0, '0);
    send_request(KIND_READ, '0, '0);
    send_request(KIND_ADVANCE, '0, '0);
    send_request(KIND_START, '0, '0);
    send_request(KIND_READ, '0, '0);

    // random part: the table fills slowly, so every fill level gets traffic
    // before the full-table phase takes over
    issued    = 0;
    mood_mark = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= mood_mark) begin
        in_calm   = ($urandom_range(0, 3) == 0);
        mood_mark = issued + 80;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // well-formed walk over every stored pair, ending past the end
        walk_len = sb.pair_count;
        send_request(KIND_START, $urandom(), $urandom());
        repeat (walk_len) begin
          send_request(KIND_READ, $urandom(), $urandom());
          send_request(KIND_ADVANCE, $urandom(), $urandom());
        end
        send_request(KIND_READ, $urandom(), $urandom());
        send_request(KIND_ADVANCE, $urandom(), $urandom());
        issued += 2 * walk_len + 3;
      end else begin
        pick = $urandom_range(0, 99);
        // late in the run the table is pushed to full if it is not yet
        if (pick < 3 || (issued > 900 && sb.pair_count < TABLE_DEPTH)) begin
          send_request(KIND_INSERT, pick_word(), pick_word());
        end else if (pick < 13) begin
          send_request(KIND_INSERT, stored_key(), pick_word());
        end else if (pick < 38) begin
          send_request(KIND_LOOKUP, stored_key(), $urandom());
        end else if (pick < 50) begin
          // near miss: one bit away from a stored key, or any word
          key = stored_key();
          if ($urandom_range(0, 1)) key[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
          else key = $urandom();
          send_request(KIND_LOOKUP, key, $urandom());
        end else if (pick < 58) begin
          send_request(KIND_START, $urandom(), $urandom());
        end else if (pick < 77) begin
          send_request(KIND_READ, $urandom(), $urandom());
        end else if (pick < 96) begin
          send_request(KIND_ADVANCE, $urandom(), $urandom());
        end else begin
          send_request(KIND_LOGIC_SPARE(), $urandom(), $urandom());
        end
        issued++;
      end
    end
    in_valid <= 1'b0;

    // drain, then give a stray beat time to show up
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.report("results still expected at end of run");

    $display("%0d requests sent, %0d results checked, table holds %0d of %0d pairs",
             requests_sent, sb.results_checked, sb.pair_count, TABLE_DEPTH);
    $display("status mix: ok %0d, not found %0d, exists %0d, full %0d, at end %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout at %0t", $realtime);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
